/* rtl/core/assert_macros.svh */
// ============================================================================
// assert_macros.svh
// Shared assertion macros for the RGB fade sequencer RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RFS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rfs_pkg.sv */
// ============================================================================
// rfs_pkg
// Types and constants shared by the RGB fade sequencer modules.
// ============================================================================
package rfs_pkg;

    // Default sizing of the block.
    localparam int TABLE_DEPTH_DEF    = 16;
    localparam int TICKS_PER_STEP_DEF = 10;

    // Field widths.
    localparam int ACTION_W     = 2;
    localparam int INDEX_W      = 4;
    localparam int INTERVAL_W   = 6;
    localparam int COLOR_W      = 8;
    localparam int ACC_W        = 16;
    localparam int STEP_W       = ACC_W + 1;
    localparam int SEQ_LEN_W    = 5;
    localparam int INTERVAL_MAX = (1 << INTERVAL_W) - 1;

    // Color channels: red, green, blue.
    localparam int NUM_CHAN = 3;
    localparam int CHAN_W   = 2;

    // Action codes carried in the input word.
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

    // Input word.
    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [INDEX_W-1:0]    entry_index;
        logic [INTERVAL_W-1:0] entry_interval;
        logic [COLOR_W-1:0]    entry_red;
        logic [COLOR_W-1:0]    entry_green;
        logic [COLOR_W-1:0]    entry_blue;
    } rfs_in_t;

    // Result word.
    typedef struct packed {
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
        logic               wrapped;
    } rfs_out_t;

    // One command table entry.
    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;
        logic [COLOR_W-1:0]    red;
        logic [COLOR_W-1:0]    green;
        logic [COLOR_W-1:0]    blue;
    } rfs_entry_t;

    // Status of the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* rtl/core/rfs_ram.sv */
// ============================================================================
// rfs_ram
// Generic RAM with one write port and one registered read port.
// ============================================================================
module rfs_ram #(
    parameter int  WIDTH  = 30,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/rfs_div.sv */
// ============================================================================
// rfs_div
// Restoring unsigned divider that develops one quotient bit per cycle.
// ============================================================================
`include "assert_macros.svh"

module rfs_div #(
    parameter int DIVIDEND_W = rfs_pkg::ACC_W,
    parameter int DIVISOR_W  = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIVIDEND_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0]     divisor,
    output rfs_pkg::div_status_t     status,
    output logic [DIVIDEND_W-1:0]    quotient
);

    import rfs_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] num_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // Bring down the next dividend bit and try the subtraction.
    assign rem_shift = {rem_reg, num_reg[DIVIDEND_W-1]};
    assign trial     = rem_shift - {1'b0, den_reg};
    assign fits      = ~trial[DIVISOR_W];

    // Sequencing: count the quotient bits and flag completion.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out at the top while quotient bits enter below.
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? trial[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = num_reg;

    `RFS_ASSERT_IMP(a_rem_below_divisor, aclk, aresetn, busy_reg, rem_reg < den_reg, "partial remainder reached the divisor")

endmodule

/* rtl/core/rgb_fade_sequencer_top.sv */
// ============================================================================
// rgb_fade_sequencer_top
// Plays a table of fade commands as linear RGB fades in 8.8 fixed point.
// Input words (s_valid/s_ready) carry an action: tick, write a table entry,
// or restart at entry 0. Every accepted word yields exactly one result word
// (m_valid/m_ready) with the current color and the wrapped flag.
// A tick inside the running fade or a table write goes to the done state and
// then loads the output register. A tick that ends an entry, or a restart,
// loads the next entry and runs a shared bit-serial divider for the three
// channel steps, unless the entry's interval is zero. A restart skips the
// snap state. One word is in work at a time; s_ready is high whenever the
// sequencer is idle, even while a finished result waits on the output
// register. If the receiver stalls, the next result waits in the sequencer
// until the output register frees up. The user writes the sequence length
// register through cfg_wr_en/cfg_wr_data only while the block is idle; the
// block does not enforce this. After reset the color is black, entry 0 is
// current with a zero budget, and the length is 1.
// ============================================================================
`include "assert_macros.svh"

module rgb_fade_sequencer_top #(
    parameter int TABLE_DEPTH    = rfs_pkg::TABLE_DEPTH_DEF,
    parameter int TICKS_PER_STEP = rfs_pkg::TICKS_PER_STEP_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  rfs_pkg::rfs_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output rfs_pkg::rfs_out_t              m_data,
    input  logic                           cfg_wr_en,
    input  logic [rfs_pkg::SEQ_LEN_W-1:0]  cfg_wr_data
);

    import rfs_pkg::*;

    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LEN_W   = $clog2(TABLE_DEPTH + 1);
    localparam int TICKS_W = $clog2(INTERVAL_MAX * TICKS_PER_STEP + 1);
    localparam int ENTRY_W = $bits(rfs_entry_t);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SNAP    = 6'b000010,
        ST_LOAD    = 6'b000100,
        ST_DIV_SET = 6'b001000,
        ST_DIV_RUN = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ACC_W-1:0]           acc_reg [NUM_CHAN];
    logic [ACC_W-1:0]           acc_next [NUM_CHAN];
    logic signed [STEP_W-1:0]   step_reg [NUM_CHAN];
    logic signed [STEP_W-1:0]   step_next [NUM_CHAN];
    logic [COLOR_W-1:0]         target_reg [NUM_CHAN];
    logic [COLOR_W-1:0]         target_next [NUM_CHAN];
    logic [ADDR_W-1:0]          play_index_reg, play_index_next;
    logic [TICKS_W-1:0]         tick_count_reg, tick_count_next;
    logic [TICKS_W-1:0]         cmd_ticks_reg, cmd_ticks_next;
    logic [SEQ_LEN_W-1:0]       seq_len_reg;
    logic                       entry0_valid_reg, entry0_valid_next;
    logic                       rd_zero_reg;
    logic                       wrap_reg, wrap_next;
    logic [CHAN_W-1:0]          chan_reg, chan_next;
    logic                       neg_reg, neg_next;
    logic                       m_valid_reg, m_valid_next;
    rfs_out_t                   m_data_reg;

    logic                       ram_we;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ENTRY_W-1:0]         ram_rdata;
    rfs_entry_t                 wr_entry;
    rfs_entry_t                 rd_entry;
    logic [LEN_W-1:0]           play_len;
    logic [ADDR_W:0]            idx_inc;
    logic [STEP_W-1:0]          diff;
    logic [ACC_W-1:0]           diff_mag;
    logic [STEP_W-1:0]          quot_ext;
    logic                       div_start;
    div_status_t                div_status;
    logic [ACC_W-1:0]           div_quot;
    logic                       out_load;

    // Command table.
    assign wr_entry.interval = s_data.entry_interval;
    assign wr_entry.red      = s_data.entry_red;
    assign wr_entry.green    = s_data.entry_green;
    assign wr_entry.blue     = s_data.entry_blue;

    rfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ADDR_W'(s_data.entry_index)),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Entry 0 reads as zero until it is first written.
    assign rd_entry = rd_zero_reg ? '0 : rfs_entry_t'(ram_rdata);

    // Played length, clamped to one entry at least and the table depth at most.
    always_comb begin
        if (seq_len_reg == '0) begin
            play_len = LEN_W'(1);
        end else if (32'(seq_len_reg) > TABLE_DEPTH) begin
            play_len = LEN_W'(TABLE_DEPTH);
        end else begin
            play_len = LEN_W'(seq_len_reg);
        end
    end

    assign idx_inc = {1'b0, play_index_reg} + (ADDR_W + 1)'(1);

    // Signed distance to the target for the channel in work, and its magnitude.
    assign diff     = {1'b0, target_reg[chan_reg], 8'h00} - {1'b0, acc_reg[chan_reg]};
    assign diff_mag = diff[STEP_W-1] ? ACC_W'(~diff + STEP_W'(1)) : diff[ACC_W-1:0];
    assign quot_ext = {1'b0, div_quot};

    // Shared serial divider for the per-channel steps.
    rfs_div #(
        .DIVIDEND_W (ACC_W),
        .DIVISOR_W  (TICKS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (diff_mag),
        .divisor  (cmd_ticks_reg),
        .status   (div_status),
        .quotient (div_quot)
    );

    // Sequencer control.
    always_comb begin
        state_next        = state_reg;
        play_index_next   = play_index_reg;
        tick_count_next   = tick_count_reg;
        cmd_ticks_next    = cmd_ticks_reg;
        entry0_valid_next = entry0_valid_reg;
        wrap_next         = wrap_reg;
        chan_next         = chan_reg;
        neg_next          = neg_reg;
        ram_we            = 1'b0;
        rd_addr           = play_index_reg;
        div_start         = 1'b0;
        out_load          = 1'b0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            acc_next[c]    = acc_reg[c];
            step_next[c]   = step_reg[c];
            target_next[c] = target_reg[c];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    wrap_next = 1'b0;
                    unique case (s_data.action)
                        ACT_TICK: begin
                            if (tick_count_reg < cmd_ticks_reg) begin
                                for (int c = 0; c < NUM_CHAN; c++) begin
                                    acc_next[c] = acc_reg[c] + step_reg[c][ACC_W-1:0];
                                end
                                tick_count_next = tick_count_reg + TICKS_W'(1);
                                state_next      = ST_DONE;
                            end else begin
                                state_next = ST_SNAP;
                            end
                        end
                        ACT_WRITE: begin
                            if (32'(s_data.entry_index) < TABLE_DEPTH) begin
                                ram_we = 1'b1;
                                if (s_data.entry_index == '0) begin
                                    entry0_valid_next = 1'b1;
                                end
                            end
                            state_next = ST_DONE;
                        end
                        ACT_RESTART: begin
                            play_index_next = '0;
                            rd_addr         = '0;
                            state_next      = ST_LOAD;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SNAP: begin
                // Budget used up: land on the target and advance the sequence.
                acc_next[0] = {rd_entry.red, 8'h00};
                acc_next[1] = {rd_entry.green, 8'h00};
                acc_next[2] = {rd_entry.blue, 8'h00};
                if (32'(idx_inc) < 32'(play_len)) begin
                    play_index_next = idx_inc[ADDR_W-1:0];
                end else begin
                    play_index_next = '0;
                    wrap_next       = 1'b1;
                end
                rd_addr    = play_index_next;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd_ticks_next  = TICKS_W'(32'(rd_entry.interval) * TICKS_PER_STEP);
                tick_count_next = '0;
                target_next[0]  = rd_entry.red;
                target_next[1]  = rd_entry.green;
                target_next[2]  = rd_entry.blue;
                chan_next       = '0;
                if (rd_entry.interval == '0) begin
                    for (int c = 0; c < NUM_CHAN; c++) begin
                        step_next[c] = '0;
                    end
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV_SET;
                end
            end
            ST_DIV_SET: begin
                div_start  = 1'b1;
                neg_next   = diff[STEP_W-1];
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (div_status.done) begin
                    step_next[chan_reg] = neg_reg ? $signed(~quot_ext + STEP_W'(1))
                                                  : $signed(quot_ext);
                    if (chan_reg == CHAN_W'(NUM_CHAN - 1)) begin
                        state_next = ST_DONE;
                    end else begin
                        chan_next  = chan_reg + CHAN_W'(1);
                        state_next = ST_DIV_SET;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            play_index_reg   <= '0;
            tick_count_reg   <= '0;
            cmd_ticks_reg    <= '0;
            seq_len_reg      <= SEQ_LEN_W'(1);
            entry0_valid_reg <= 1'b0;
            rd_zero_reg      <= 1'b0;
            wrap_reg         <= 1'b0;
            chan_reg         <= '0;
            neg_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
            for (int c = 0; c < NUM_CHAN; c++) begin
                acc_reg[c]  <= '0;
                step_reg[c] <= '0;
            end
        end else begin
            state_reg        <= state_next;
            play_index_reg   <= play_index_next;
            tick_count_reg   <= tick_count_next;
            cmd_ticks_reg    <= cmd_ticks_next;
            entry0_valid_reg <= entry0_valid_next;
            rd_zero_reg      <= (rd_addr == '0) && !entry0_valid_reg;
            wrap_reg         <= wrap_next;
            chan_reg         <= chan_next;
            neg_reg          <= neg_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_wr_en) begin
                seq_len_reg <= cfg_wr_data;
            end
            for (int c = 0; c < NUM_CHAN; c++) begin
                acc_reg[c]  <= acc_next[c];
                step_reg[c] <= step_next[c];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            target_reg[c] <= target_next[c];
        end
        if (out_load) begin
            m_data_reg.red_out   <= acc_reg[0][ACC_W-1:ACC_W-COLOR_W];
            m_data_reg.green_out <= acc_reg[1][ACC_W-1:ACC_W-COLOR_W];
            m_data_reg.blue_out  <= acc_reg[2][ACC_W-1:ACC_W-COLOR_W];
            m_data_reg.wrapped   <= wrap_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RFS_ASSERT_IMP(a_div_budget_nonzero, aclk, aresetn, (state_reg == ST_DIV_SET) || (state_reg == ST_DIV_RUN), cmd_ticks_reg != '0, "divider runs with a zero tick budget")
    `RFS_ASSERT_IMP(a_tick_in_budget, aclk, aresetn, state_reg == ST_IDLE, tick_count_reg <= cmd_ticks_reg, "tick count ran past the budget")
    `RFS_ASSERT_IMP(a_wrap_at_entry0, aclk, aresetn, (state_reg == ST_DONE) && wrap_reg, play_index_reg == '0, "wrapped flagged away from entry 0")
    `RFS_ASSERT_NXT(a_div_started, aclk, aresetn, state_reg == ST_DIV_SET, div_status.busy, "divider did not start")

endmodule
